// ===== sv/brb_pkg.sv =====
// Shared types and constants for the byte ring buffer.
package brb_pkg;

  // Field widths of the request and result items.
  localparam int REQ_W     = 2;
  localparam int DATA_W    = 8;
  localparam int CNT_W     = 7;
  localparam int FILL_W    = 9;
  localparam int CAP_CFG_W = 9;

  // Configuration port widths and register map.
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 2'd0;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DISCARD = 2'd3;

  // One request item.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] data_in;
    logic [CNT_W-1:0]  count;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic [CNT_W-1:0]  done_count;
    logic [FILL_W-1:0] fill_level;
    logic              full_res;
    logic              empty_res;
  } res_t;

endpackage

// ===== sv/byte_ring_buffer.sv =====
// Byte ring buffer top level: pointers, fill count, byte memory and result register.
//
// A circular byte FIFO held in one single-port-read memory of DEPTH bytes. A write,
// a discard, or a read or peek that finds nothing to return gives one result; such
// items stream one per cycle while results are taken. A read or peek of n bytes gives
// n results, one per cycle while results are taken, through the registered memory
// read port, and the next item is accepted only once the last byte has reached the
// result register. Fill level and flags on every result of a request show the state
// after the whole request. Writing the capacity register (clamped to 1..DEPTH) also
// empties the buffer. Reset leaves the buffer empty with capacity 256, or DEPTH if
// smaller; no clearing pass is needed.
module byte_ring_buffer #(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  brb_pkg::req_t                 req_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output brb_pkg::res_t                 res_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]   paddr,
  input  logic [brb_pkg::PDATA_W-1:0]   pwdata,
  output logic [brb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import brb_pkg::*;

  localparam int PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = ((CAP_W > CNT_W) ? CAP_W : CNT_W) + 1;
  localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  cap;
  logic [PW-1:0]     rp;
  logic [PW-1:0]     wp;
  logic [CAP_W-1:0]  fill;
  logic [PW-1:0]     rd_ptr;
  logic [CNT_W-1:0]  remaining;
  logic [CNT_W-1:0]  burst_n;
  logic              rd_pend;
  logic              rd_last;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]     rp_next;
  logic [PW-1:0]        wp_next;
  logic [PW-1:0]        rp_next_ptr;
  logic [CAP_W-1:0]     fill_next;
  logic [CNT_W-1:0]     done_next;
  logic                 single;
  logic [CNT_W-1:0]     want;
  logic [CNT_W-1:0]     n;
  logic                 full;
  logic                 slot_free;
  logic                 accept;
  logic                 issue;
  logic                 move;
  logic                 mem_we;
  logic                 cfg_wr;
  logic [CAP_CFG_W-1:0] cfg_raw;
  logic [CAP_W-1:0]     cfg_cap;
  logic [CAP_W-1:0]     wp_inc_w;
  logic [PW-1:0]        wp_inc;
  logic [CAP_W-1:0]     rd_inc_w;
  logic [PW-1:0]        rd_inc;
  logic [SUM_W-1:0]     rp_sum;
  logic [PW-1:0]        rp_adv;

  // Configuration port: zero-wait writes, capacity readback.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);
  assign cfg_raw = pwdata[CAP_CFG_W-1:0];
  assign prdata  = (paddr == ADDR_CAPACITY) ? PDATA_W'(cap) : '0;

  // Clamp the written capacity into 1..DEPTH.
  always_comb begin
    if (cfg_raw == '0) begin
      cfg_cap = CAP_W'(1);
    end else if (32'(cfg_raw) > DEPTH) begin
      cfg_cap = CAP_W'(DEPTH);
    end else begin
      cfg_cap = CAP_W'(cfg_raw);
    end
  end

  // Handshake and burst sequencing conditions.
  assign full      = (fill == cap);
  assign slot_free = !res_valid || res_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign move      = rd_pend && slot_free;
  assign issue     = (state == S_BURST) && (remaining != '0) && (!rd_pend || slot_free);
  assign mem_we    = accept && (req_item.req_type == REQ_WRITE) && !full;

  // Byte count granted: request clipped to the burst limit and the fill level.
  always_comb begin
    if (32'(req_item.count) > MAX_BURST) begin
      want = CNT_W'(MAX_BURST);
    end else begin
      want = req_item.count;
    end
    if (32'(fill) < 32'(want)) begin
      n = CNT_W'(fill);
    end else begin
      n = want;
    end
  end

  // Pointer steps; every sum stays below twice the capacity, so one subtract wraps it.
  always_comb begin
    wp_inc_w = CAP_W'(wp) + CAP_W'(1);
    wp_inc   = (wp_inc_w == cap) ? '0 : PW'(wp_inc_w);
    rd_inc_w = CAP_W'(rd_ptr) + CAP_W'(1);
    rd_inc   = (rd_inc_w == cap) ? '0 : PW'(rd_inc_w);
    rp_sum   = SUM_W'(rp) + SUM_W'(n);
    if (rp_sum >= SUM_W'(cap)) begin
      rp_sum = rp_sum - SUM_W'(cap);
    end
    rp_adv = PW'(rp_sum);
  end

  // State after the request that is being accepted.
  always_comb begin
    rp_next_ptr = rp;
    wp_next     = wp;
    fill_next   = fill;
    done_next   = '0;
    single      = 1'b1;
    unique case (req_item.req_type)
      REQ_WRITE: begin
        if (!full) begin
          wp_next   = wp_inc;
          fill_next = fill + CAP_W'(1);
          done_next = CNT_W'(1);
        end
      end
      REQ_READ: begin
        rp_next_ptr = rp_adv;
        fill_next   = fill - CAP_W'(n);
        done_next   = n;
        single      = (n == '0);
      end
      REQ_PEEK: begin
        done_next = n;
        single    = (n == '0);
      end
      REQ_DISCARD: begin
        rp_next_ptr = rp_adv;
        fill_next   = fill - CAP_W'(n);
        done_next   = n;
      end
      default: begin
        single = 1'b1;
      end
    endcase
  end
  assign rp_next = CAP_W'(rp_next_ptr);

  // Byte memory. Writes happen only between bursts, so a read never meets a write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= req_item.data_in;
    end
    if (issue) begin
      rdata <= mem[rd_ptr];
    end
  end

  // Sequencer, pointers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_W'(CAP_RST);
      rp        <= '0;
      wp        <= '0;
      fill      <= '0;
      remaining <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Pointers and fill count.
      if (cfg_wr) begin
        cap  <= cfg_cap;
        rp   <= '0;
        wp   <= '0;
        fill <= '0;
      end else if (accept) begin
        rp   <= PW'(rp_next);
        wp   <= wp_next;
        fill <= fill_next;
      end

      // Burst control: start on a read or peek that returns bytes.
      unique case (state)
        S_IDLE: begin
          if (accept && !single) begin
            state     <= S_BURST;
            rd_ptr    <= rp;
            remaining <= n;
            burst_n   <= n;
          end
        end
        S_BURST: begin
          if (issue) begin
            rd_ptr    <= rd_inc;
            remaining <= remaining - CNT_W'(1);
            rd_pend   <= 1'b1;
            rd_last   <= (remaining == CNT_W'(1));
          end else if (move) begin
            rd_pend <= 1'b0;
          end
          if ((remaining == '0) && (!rd_pend || move)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Result register: single results at accept, burst bytes from the memory.
      if (accept && single) begin
        res_valid             <= 1'b1;
        res_item.data_out     <= '0;
        res_item.data_valid   <= 1'b0;
        res_item.last         <= 1'b1;
        res_item.done_count   <= done_next;
        res_item.fill_level   <= FILL_W'(fill_next);
        res_item.full_res     <= (fill_next == cap);
        res_item.empty_res    <= (fill_next == '0);
      end else if (move) begin
        res_valid             <= 1'b1;
        res_item.data_out     <= rdata;
        res_item.data_valid   <= 1'b1;
        res_item.last         <= rd_last;
        res_item.done_count   <= rd_last ? burst_n : '0;
        res_item.fill_level   <= FILL_W'(fill);
        res_item.full_res     <= full;
        res_item.empty_res    <= (fill == '0);
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The fill count never exceeds the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= cap)
    else $error("fill count above capacity");

  // Both pointers stay inside the capacity.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (CAP_W'(rp) < cap) && (CAP_W'(wp) < cap))
    else $error("pointer beyond capacity");

  // An empty or full buffer has equal pointers.
  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    ((fill == '0) || (fill == cap)) |-> (rp == wp))
    else $error("pointers disagree with fill count");

  // A fetched byte waiting on a stalled result is held, not overwritten.
  a_fetch_hold: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && res_valid && !res_ready) |=> (rd_pend && $stable(rdata)))
    else $error("fetched byte lost under stall");

  // Only the last result of a request carries a byte count.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_item.last) |-> (res_item.done_count == '0))
    else $error("byte count on a result before the last");

endmodule

// ===== tb/sv/byte_ring_buffer_tb.sv =====
// Self-checking testbench for the byte ring buffer: directed and random requests with checking.
module byte_ring_buffer_tb;
  import brb_pkg::*;

  localparam int MEM_DEPTH  = 256;
  localparam int BURST_MAX  = 64;
  localparam int LONG_HOLD  = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTED = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req_item = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  res_t               res_item;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Requests waiting to be offered, and results the buffer still owes us.
  req_t request_queue[$];
  res_t due_results[$];

  // Shadow copy of the buffer contents, pointers and capacity.
  logic [7:0] shadow_bytes [MEM_DEPTH];
  int         shadow_rd = 0;
  int         shadow_wr = 0;
  logic       shadow_full = 1'b0;
  int         shadow_cap = MEM_DEPTH;

  int err_count = 0;
  int cycle_count = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int data_results = 0;
  int full_results = 0;
  int cap_writes = 0;
  int gap_left = 0;
  int burst_left = 1;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_cycles = 0;
  logic long_hold_arm = 1'b0;
  logic long_hold_done = 1'b0;

  byte_ring_buffer #(
    .DEPTH(MEM_DEPTH),
    .MAX_BURST(BURST_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_item(req_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item(res_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Free-running clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  // Number of bytes currently held by the shadow buffer.
  function automatic int shadow_fill();
    if (shadow_full) begin
      return shadow_cap;
    end
    if (shadow_wr >= shadow_rd) begin
      return shadow_wr - shadow_rd;
    end
    return shadow_cap + shadow_wr - shadow_rd;
  endfunction

  // Builds one result with the fill level and flags of the current shadow state.
  function automatic res_t make_result(input logic [7:0] data, input logic valid,
                                       input logic fin, input int done);
    res_t r;
    int   fill;
    fill = shadow_fill();
    r.data_out   = data;
    r.data_valid = valid;
    r.last       = fin;
    r.done_count = done[CNT_W-1:0];
    r.fill_level = fill[FILL_W-1:0];
    r.full_res   = shadow_full;
    r.empty_res  = (fill == 0);
    return r;
  endfunction

  // Applies one accepted request to the shadow buffer and queues the results it owes.
  function automatic void step_buffer_model(input req_t rq);
    int         want;
    int         n;
    int         p;
    int         done;
    logic [7:0] got [BURST_MAX];
    want = (rq.count > BURST_MAX) ? BURST_MAX : int'(rq.count);
    n = (want < shadow_fill()) ? want : shadow_fill();
    case (rq.req_type)
      REQ_WRITE: begin
        // A write to a full buffer drops the byte.
        done = 0;
        if (!shadow_full) begin
          shadow_bytes[shadow_wr] = rq.data_in;
          shadow_wr = (shadow_wr + 1) % shadow_cap;
          shadow_full = (shadow_wr == shadow_rd);
          done = 1;
        end
        due_results.push_back(make_result(8'h00, 1'b0, 1'b1, done));
      end
      REQ_DISCARD: begin
        if (n > 0) begin
          shadow_rd = (shadow_rd + n) % shadow_cap;
          shadow_full = 1'b0;
        end
        due_results.push_back(make_result(8'h00, 1'b0, 1'b1, n));
      end
      REQ_READ, REQ_PEEK: begin
        if (n == 0) begin
          due_results.push_back(make_result(8'h00, 1'b0, 1'b1, 0));
        end else begin
          p = shadow_rd;
          for (int i = 0; i < n; i++) begin
            got[i] = shadow_bytes[p];
            p = (p + 1) % shadow_cap;
          end
          // Only a read moves the read pointer; flags reflect the state after the request.
          if (rq.req_type == REQ_READ) begin
            shadow_rd = p;
            shadow_full = 1'b0;
          end
          for (int i = 0; i < n; i++) begin
            due_results.push_back(make_result(got[i], 1'b1, i == n - 1,
                                              (i == n - 1) ? n : 0));
          end
        end
      end
    endcase
  endfunction

  function automatic void push_request(input logic [REQ_W-1:0] kind, input logic [7:0] data,
                                       input int cnt);
    req_t rq;
    rq.req_type = kind;
    rq.data_in  = data;
    rq.count    = cnt[CNT_W-1:0];
    request_queue.push_back(rq);
  endfunction

  // Random request: mostly small counts, some up to the burst limit, a few beyond it.
  function automatic req_t random_request(input int write_pct);
    req_t rq;
    int   roll;
    int   op;
    roll = $urandom_range(0, 99);
    if (roll < write_pct) begin
      rq.req_type = REQ_WRITE;
    end else begin
      op = $urandom_range(0, 2);
      rq.req_type = (op == 0) ? REQ_READ : (op == 1) ? REQ_PEEK : REQ_DISCARD;
    end
    rq.data_in = DATA_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      rq.count = CNT_W'($urandom_range(0, 8));
    end else if (roll < 95) begin
      rq.count = CNT_W'($urandom_range(9, 64));
    end else begin
      rq.count = CNT_W'($urandom_range(65, 127));
    end
    return rq;
  endfunction

  // Waits until every request is taken and every owed result has arrived.
  task automatic wait_until_drained();
    while (request_queue.size() != 0 || req_valid || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Register write in a setup phase and an access phase; the shadow buffer is emptied along with the real one.
  task automatic write_capacity(input logic [PDATA_W-1:0] value);
    int v;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = int'(value[CAP_CFG_W-1:0]);
    shadow_cap  = (v == 0) ? 1 : (v > MEM_DEPTH) ? MEM_DEPTH : v;
    shadow_rd   = 0;
    shadow_wr   = 0;
    shadow_full = 1'b0;
    cap_writes++;
    @(negedge clk);
    // The register reads back the clamped capacity, and the port never waits.
    if (prdata !== PDATA_W'(shadow_cap)) begin
      flag_mismatch($sformatf("capacity read back %0d, expected %0d", prdata, shadow_cap));
    end
    if (pready !== 1'b1) begin
      flag_mismatch("configuration port not ready");
    end
  endtask

  task automatic run_random_phase(input logic [PDATA_W-1:0] cap_value, input int n_items,
                                  input int write_pct);
    wait_until_drained();
    write_capacity(cap_value);
    for (int i = 0; i < n_items; i++) begin
      request_queue.push_back(random_request(write_pct));
    end
  endtask

  // Request driver: offers queued items in bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      gap_left   <= 0;
      burst_left <= 1;
    end else begin
      if (req_valid && req_ready) begin
        step_buffer_model(req_item);
        requests_taken++;
      end
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          req_item  <= request_queue.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: switches between stall patterns, with one long hold-off when armed.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (long_hold_arm && !long_hold_done) begin
      if (hold_cycles == LONG_HOLD) begin
        long_hold_done <= 1'b1;
        res_ready      <= 1'b1;
      end else begin
        hold_cycles <= hold_cycles + 1;
        res_ready   <= 1'b0;
      end
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: res_ready <= 1'b1;
        1: res_ready <= ($urandom_range(0, 9) < 7);
        2: res_ready <= ~res_ready;
        default: res_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Result monitor: compares each accepted result with the oldest owed one.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (res_item.data_valid === 1'b1) begin
        data_results++;
      end
      if (res_item.full_res === 1'b1) begin
        full_results++;
      end
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing expected", res_item));
      end else begin
        want = due_results.pop_front();
        check_field("data_out", 9'(res_item.data_out), 9'(want.data_out));
        check_field("data_valid", 9'(res_item.data_valid), 9'(want.data_valid));
        check_field("last", 9'(res_item.last), 9'(want.last));
        check_field("done_count", 9'(res_item.done_count), 9'(want.done_count));
        check_field("fill_level", res_item.fill_level, want.fill_level);
        check_field("full_res", 9'(res_item.full_res), 9'(want.full_res));
        check_field("empty_res", 9'(res_item.empty_res), 9'(want.empty_res));
      end
    end
  end

  // Cycle counter with a timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty buffer at reset capacity, then a few bytes, peeks, saturated counts.
    push_request(REQ_READ, 8'h00, 0);
    push_request(REQ_READ, 8'h00, 3);
    push_request(REQ_PEEK, 8'h00, 1);
    push_request(REQ_DISCARD, 8'h00, 5);
    push_request(REQ_WRITE, 8'h00, 0);
    push_request(REQ_WRITE, 8'hFF, 127);
    push_request(REQ_WRITE, 8'h5A, 0);
    push_request(REQ_WRITE, 8'hA5, 0);
    push_request(REQ_PEEK, 8'h00, 0);
    push_request(REQ_PEEK, 8'h00, 2);
    push_request(REQ_READ, 8'h00, 127);
    push_request(REQ_WRITE, 8'h81, 0);
    push_request(REQ_WRITE, 8'h7E, 0);
    push_request(REQ_DISCARD, 8'hFF, 127);

    // Capacity two: a write to a full buffer is dropped, and pointers wrap.
    wait_until_drained();
    write_capacity(32'd2);
    push_request(REQ_WRITE, 8'h11, 0);
    push_request(REQ_WRITE, 8'h22, 0);
    push_request(REQ_WRITE, 8'h33, 0);
    push_request(REQ_PEEK, 8'h00, 64);
    push_request(REQ_DISCARD, 8'h00, 1);
    push_request(REQ_WRITE, 8'h44, 0);
    push_request(REQ_READ, 8'h00, 2);

    // Capacity zero behaves as capacity one.
    wait_until_drained();
    write_capacity(32'd0);
    push_request(REQ_WRITE, 8'h01, 0);
    push_request(REQ_WRITE, 8'h02, 0);
    push_request(REQ_READ, 8'h00, 1);
    push_request(REQ_READ, 8'h00, 1);

    // Random phases over a spread of capacities, including clamped values.
    run_random_phase(32'd3, 50, 55);
    run_random_phase(32'hFFFF_FE05, 40, 55);
    run_random_phase(32'd17, 50, 60);
    wait_until_drained();
    long_hold_arm = 1'b1;
    run_random_phase(32'd256, 80, 70);
    run_random_phase(32'd511, 50, 55);
    run_random_phase(32'd64, 60, 60);
    run_random_phase(32'd1, 40, 50);
    run_random_phase(32'd2, 40, 50);
    run_random_phase(32'd100, 70, 65);

    wait_until_drained();
    repeat (80) @(posedge clk);

    $display("Ran %0d requests over %0d capacity settings in %0d cycles.",
             requests_taken, cap_writes, cycle_count);
    $display("Checked %0d results: %0d carrying bytes, %0d with the buffer full.",
             results_seen, data_results, full_results);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
